### rtl/core/bti_pkg.sv
// Package for the bilinear table interpolator: types, op codes and sizes.
`default_nettype none
package bti_pkg;
   localparam int MaxAltDefault = 16;
   localparam int MaxSpdDefault = 16;

   typedef enum logic [1:0] {
      OP_LOAD_ALT  = 2'd0,
      OP_LOAD_SPD  = 2'd1,
      OP_LOAD_GRID = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

   typedef enum logic {
      CSR_ALT_USED = 1'b0,
      CSR_SPD_USED = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_DIV,
      ST_S_RD,
      ST_S_CHK,
      ST_S_DIV,
      ST_G_RD,
      ST_G_MUL,
      ST_Y_MUL,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

### rtl/core/bilinear_table_interpolator_unit.sv
// Top level of the bilinear table interpolator: level and grid memories and sequencer.
`default_nettype none
// Use: a beat on the request channel is taken when req_start is high and req_busy
// is low. Ops 0 to 2 load one altitude level, one speed level or one grid entry and
// give no result; a load leaves req_busy low and the next beat may follow at once.
// Op 3 is a query: the altitude and then the speed are bracketed by walking their
// level memory one level at a time (read, then compare), after the first and the
// last level have been checked. Each fraction between two distinct levels comes
// from a restoring divider (one leading compare and 16 quotient bits). The four grid
// corners are read in turn and blended by one shared multiplier, which then also
// blends the rows. A query on an empty table is busy for one cycle only.
// The result beat appears on rsp_rate_out and rsp_status for exactly one cycle with
// rsp_valid, in the first cycle in which req_busy is low again; the next request can
// be taken in that same cycle. The receiver cannot stall, so nothing is held back.
// The used-level counts are written through the csr_ channel, which is always ready;
// write them only while the block is idle. Reset clears the counts and the sequencer;
// the memories are not cleared and must be written before they are read.
module bilinear_table_interpolator_unit
   #(
      parameter int MAX_ALTITUDE_LEVELS = bti_pkg::MaxAltDefault,
      parameter int MAX_SPEED_LEVELS    = bti_pkg::MaxSpdDefault
   )
   (
      input  wire logic        clock,
      input  wire logic        reset,
      input  wire logic        req_start,
      output      logic        req_busy,
      input  wire logic [1:0]  req_op,
      input  wire logic [3:0]  req_altitude_index,
      input  wire logic [3:0]  req_speed_index,
      input  wire logic [15:0] req_load_value,
      input  wire logic [15:0] req_query_altitude,
      input  wire logic [15:0] req_query_speed,
      output      logic        rsp_valid,
      output      logic [19:0] rsp_rate_out,
      output      logic        rsp_status,
      input  wire logic        csr_valid,
      output      logic        csr_ready,
      input  wire logic        csr_index,
      input  wire logic [4:0]  csr_data
   );
   import bti_pkg::*;

   localparam int AW = (MAX_ALTITUDE_LEVELS > 1) ? $clog2(MAX_ALTITUDE_LEVELS) : 1;
   localparam int SW = (MAX_SPEED_LEVELS > 1) ? $clog2(MAX_SPEED_LEVELS) : 1;
   localparam int GD = MAX_ALTITUDE_LEVELS * MAX_SPEED_LEVELS;
   localparam int GW = $clog2(GD);

   // Memories.
   logic [15:0] alt_mem [MAX_ALTITUDE_LEVELS];
   logic [15:0] spd_mem [MAX_SPEED_LEVELS];
   logic [15:0] grid_mem [GD];

   logic [4:0] alt_used_ff, spd_used_ff;
   logic [8:0] na_c, ns_c;

   state_type state_ff, state_in;
   logic [8:0]  idx_ff, idx_in;
   logic [8:0]  last_c;
   logic [15:0] x_ff, x_in, qs_ff, qs_in;
   logic [15:0] prev_ff, prev_in;
   logic [15:0] rd_level;
   logic [AW-1:0] a0_ff, a0_in, a1_ff, a1_in;
   logic [SW-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [16:0] ty_ff, ty_in, tx_ff, tx_in;
   logic [15:0] num_ff, num_in, den_ff, den_in;
   logic [16:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  corner_ff, corner_in;
   logic [32:0] acc_ff, acc_in;
   logic [32:0] r1_ff, r1_in;
   logic [49:0] res_ff, res_in;
   logic        phase_ff, phase_in;
   logic [19:0] rate_ff, rate_in;
   logic        stat_ff, stat_in, vld_ff, vld_in;

   logic        a_rd_en, s_rd_en, g_rd_en;
   logic [AW-1:0] a_rd_addr;
   logic [SW-1:0] s_rd_addr;
   logic [GW-1:0] g_rd_addr;
   logic [15:0] alt_rd_ff, spd_rd_ff, grid_rd_ff;
   logic        rd_sel_a;
   logic        walk_done;
   logic [32:0] prod_c;
   logic [16:0] mul_a;
   logic [32:0] mul_b;
   logic [49:0] prod_w;

   assign na_c = (9'(alt_used_ff) > 9'(MAX_ALTITUDE_LEVELS)) ?
                 9'(MAX_ALTITUDE_LEVELS) : 9'(alt_used_ff);
   assign ns_c = (9'(spd_used_ff) > 9'(MAX_SPEED_LEVELS)) ?
                 9'(MAX_SPEED_LEVELS) : 9'(spd_used_ff);

   wire accept = req_start && !req_busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_used_ff <= '0;
         spd_used_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_ALT_USED: alt_used_ff <= csr_data;
            CSR_SPD_USED: spd_used_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Memory writes on load beats, registered reads during a query.
   always_ff @(posedge clock) begin
      if (accept && op_type'(req_op) == OP_LOAD_ALT &&
          32'(req_altitude_index) < MAX_ALTITUDE_LEVELS)
         alt_mem[AW'(req_altitude_index)] <= req_load_value;
      if (accept && op_type'(req_op) == OP_LOAD_SPD &&
          32'(req_speed_index) < MAX_SPEED_LEVELS)
         spd_mem[SW'(req_speed_index)] <= req_load_value;
      if (accept && op_type'(req_op) == OP_LOAD_GRID &&
          32'(req_altitude_index) < MAX_ALTITUDE_LEVELS &&
          32'(req_speed_index) < MAX_SPEED_LEVELS)
         grid_mem[GW'(32'(req_altitude_index) * MAX_SPEED_LEVELS +
                       32'(req_speed_index))] <= req_load_value;
      if (a_rd_en) alt_rd_ff <= alt_mem[a_rd_addr];
      if (s_rd_en) spd_rd_ff <= spd_mem[s_rd_addr];
      if (g_rd_en) grid_rd_ff <= grid_mem[g_rd_addr];
   end

   assign rd_level = rd_sel_a ? alt_rd_ff : spd_rd_ff;
   assign last_c = (state_ff == ST_A_RD || state_ff == ST_A_CHK) ? na_c - 9'd1 : ns_c - 9'd1;
   assign prod_w = 50'(mul_a) * 50'(mul_b);
   // The corner products are 17 by 16 bits and always fit in 33 bits.
   assign prod_c = prod_w[32:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && op_type'(req_op) == OP_QUERY)
                      state_in = (na_c == 9'd0 || ns_c == 9'd0) ? ST_DONE : ST_A_RD;
         ST_A_RD:  state_in = ST_A_CHK;
         ST_A_CHK: if (walk_done) state_in = ST_S_RD;
                   else if (cnt_in == 5'd16) state_in = ST_A_DIV;
                   else state_in = ST_A_RD;
         ST_A_DIV: if (cnt_ff == 5'd0) state_in = ST_S_RD;
         ST_S_RD:  state_in = ST_S_CHK;
         ST_S_CHK: if (walk_done) state_in = ST_G_RD;
                   else if (cnt_in == 5'd16) state_in = ST_S_DIV;
                   else state_in = ST_S_RD;
         ST_S_DIV: if (cnt_ff == 5'd0) state_in = ST_G_RD;
         ST_G_RD:  state_in = ST_G_MUL;
         ST_G_MUL: state_in = (corner_ff == 2'd3) ? ST_Y_MUL : ST_G_RD;
         ST_Y_MUL: state_in = (phase_ff) ? ST_DONE : ST_Y_MUL;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      idx_in = idx_ff; x_in = x_ff; qs_in = qs_ff; prev_in = prev_ff;
      a0_in = a0_ff; a1_in = a1_ff; s0_in = s0_ff; s1_in = s1_ff;
      ty_in = ty_ff; tx_in = tx_ff; num_in = num_ff; den_in = den_ff;
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff; corner_in = corner_ff;
      acc_in = acc_ff; r1_in = r1_ff; res_in = res_ff;
      phase_in = phase_ff; rate_in = rate_ff; stat_in = stat_ff; vld_in = 1'b0;
      walk_done = 1'b0;
      a_rd_en = 1'b0; s_rd_en = 1'b0; g_rd_en = 1'b0;
      a_rd_addr = AW'(idx_ff); s_rd_addr = SW'(idx_ff); g_rd_addr = '0;
      rd_sel_a = (state_ff == ST_A_CHK);
      mul_a = '0; mul_b = '0;
      req_busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (accept && op_type'(req_op) == OP_QUERY) begin
               x_in = req_query_altitude; qs_in = req_query_speed;
               idx_in = 9'd0; phase_in = 1'b1; cnt_in = 5'd0; corner_in = 2'd0;
               rate_in = '0; stat_in = (na_c == 9'd0 || ns_c == 9'd0);
            end
         end
         // Walk: phase 1 reads level 0 then the last level; phase 0 scans pairs.
         ST_A_RD, ST_S_RD: begin
            if (state_ff == ST_A_RD) a_rd_en = 1'b1; else s_rd_en = 1'b1;
         end
         ST_A_CHK, ST_S_CHK: begin
            cnt_in = 5'd0;
            if (phase_ff) begin
               if (idx_ff == 9'd0) begin
                  // A value at or below the first level, or a single level, settles on level 0.
                  if (x_ff <= rd_level || last_c == 9'd0) begin
                     idx_in = 9'h1FF; phase_in = 1'b0;
                     if (rd_sel_a) begin a0_in = '0; a1_in = '0; ty_in = '0; end
                     else begin s0_in = '0; s1_in = '0; tx_in = '0; end
                  end else idx_in = last_c;
               end else begin
                  phase_in = 1'b0;
                  if (x_ff >= rd_level) begin
                     idx_in = 9'h1FF;
                     if (rd_sel_a) begin
                        a0_in = AW'(last_c); a1_in = AW'(last_c); ty_in = '0;
                     end else begin
                        s0_in = SW'(last_c); s1_in = SW'(last_c); tx_in = '0;
                     end
                  end else idx_in = 9'd0;
                  prev_in = 16'hFFFF;
                  cnt_in = 5'd1; // marks "no previous level yet"
               end
            end else begin
               // rd_level is level idx; prev_ff is level idx-1 when cnt_ff==0.
               if (cnt_ff == 5'd0 && x_ff >= prev_ff && x_ff <= rd_level) begin
                  if (rd_sel_a) begin
                     a0_in = AW'(idx_ff - 9'd1); a1_in = AW'(idx_ff);
                  end else begin
                     s0_in = SW'(idx_ff - 9'd1); s1_in = SW'(idx_ff);
                  end
                  num_in = x_ff - prev_ff; den_in = rd_level - prev_ff;
                  rem_in = '0; quo_in = '0;
                  cnt_in = 5'd16;
                  if (rd_level == prev_ff) begin
                     idx_in = 9'h1FF; cnt_in = 5'd0;
                     if (rd_sel_a) ty_in = '0; else tx_in = '0;
                  end
               end else if (idx_ff == last_c) begin
                  idx_in = 9'h1FF;
                  if (rd_sel_a) begin
                     a0_in = AW'(last_c); a1_in = AW'(last_c); ty_in = '0;
                  end else begin
                     s0_in = SW'(last_c); s1_in = SW'(last_c); tx_in = '0;
                  end
               end else begin
                  prev_in = rd_level; idx_in = idx_ff + 9'd1;
               end
            end
            walk_done = (phase_in == 1'b0 && idx_in == 9'h1FF);
            // The altitude is settled without a divide: start the speed walk.
            if (walk_done && rd_sel_a) begin
               x_in = qs_ff; idx_in = 9'd0; phase_in = 1'b1; cnt_in = 5'd0;
            end
         end
         // Restoring divide: (num << 16) / den, a leading compare then one bit per cycle.
         ST_A_DIV, ST_S_DIV: begin
            if (cnt_ff == 5'd16) begin
               // The fraction reaches one when the value sits on the upper level.
               if (num_ff >= den_ff) begin
                  rem_in = 17'(num_ff - den_ff);
                  quo_in = 17'd1;
               end else begin
                  rem_in = 17'(num_ff);
                  quo_in = '0;
               end
               num_in = '0;
               cnt_in = cnt_ff - 5'd1;
            end else begin
               if (18'(rem_ff) * 2 >= 18'(den_ff)) begin
                  rem_in = 17'((18'(rem_ff) * 2) - 18'(den_ff));
                  quo_in = {quo_ff[15:0], 1'b1};
               end else begin
                  rem_in = 17'(18'(rem_ff) * 2);
                  quo_in = {quo_ff[15:0], 1'b0};
               end
               if (cnt_ff == 5'd0) begin
                  if (state_ff == ST_A_DIV) begin
                     ty_in = quo_in; x_in = qs_ff; idx_in = 9'd0;
                     phase_in = 1'b1;
                  end else tx_in = quo_in;
                  corner_in = 2'd0;
               end else cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_G_RD: begin
            // Corner order: (a0,s0), (a0,s1), (a1,s0), (a1,s1).
            g_rd_en = 1'b1;
            g_rd_addr = GW'(32'(corner_ff[1] ? a1_ff : a0_ff) * MAX_SPEED_LEVELS +
                            32'(corner_ff[0] ? s1_ff : s0_ff));
            phase_in = 1'b0;
         end
         ST_G_MUL: begin
            mul_a = corner_ff[0] ? tx_ff : (17'h10000 - tx_ff);
            mul_b = 33'(grid_rd_ff);
            if (corner_ff[0]) begin
               if (corner_ff[1]) acc_in = acc_ff + prod_c;
               else r1_in = acc_ff + prod_c;
            end else acc_in = prod_c;
            corner_in = corner_ff + 2'd1;
         end
         ST_Y_MUL: begin
            // Row blend: r1*(1-ty), then + r2*ty, with r2 held in acc.
            if (!phase_ff) begin
               mul_a = 17'h10000 - ty_ff; mul_b = r1_ff;
               res_in = prod_w; phase_in = 1'b1;
            end else begin
               mul_a = ty_ff; mul_b = acc_ff;
               res_in = res_ff + prod_w;
               rate_in = res_in[47:28];
            end
         end
         ST_DONE: vld_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
      idx_ff <= idx_in; x_ff <= x_in; qs_ff <= qs_in; prev_ff <= prev_in;
      a0_ff <= a0_in; a1_ff <= a1_in; s0_ff <= s0_in; s1_ff <= s1_in;
      ty_ff <= ty_in; tx_ff <= tx_in; num_ff <= num_in; den_ff <= den_in;
      quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in; corner_ff <= corner_in;
      acc_ff <= acc_in; r1_ff <= r1_in; res_ff <= res_in;
      phase_ff <= phase_in; rate_ff <= rate_in; stat_ff <= stat_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_rate_out = rate_ff;
   assign rsp_status = stat_ff;

`ifndef ASSERT_OFF
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat repeated");
   a_busy_after_query: assert property (@(posedge clock) disable iff (reset)
      (req_start && !req_busy && op_type'(req_op) == OP_QUERY) |=> req_busy)
      else $error("query not started");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_rate_out == 20'd0))
      else $error("empty table gave a rate");
`endif
endmodule
`default_nettype wire

### tb/tb_bilinear_table_interpolator_unit.sv
// Self-checking testbench for the bilinear table interpolator: directed table then random loads and queries.
module tb_bilinear_table_interpolator_unit;
   import bti_pkg::*;

   localparam int NUM_ALT = 16;
   localparam int NUM_SPD = 16;
   localparam int ONE_Q16 = 65536;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;
   // A quiet spell of this length, far longer than any query, means a hang.
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 150;
   localparam int RANDOM_PER_PHASE = 150;

   logic        clock;
   logic        reset;
   logic        req_start;
   logic        req_busy;
   logic [1:0]  req_op;
   logic [3:0]  req_altitude_index;
   logic [3:0]  req_speed_index;
   logic [15:0] req_load_value;
   logic [15:0] req_query_altitude;
   logic [15:0] req_query_speed;
   logic        rsp_valid;
   logic [19:0] rsp_rate_out;
   logic        rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [4:0]  csr_data;

   bilinear_table_interpolator_unit DUT (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_busy(req_busy), .req_op(req_op),
      .req_altitude_index(req_altitude_index), .req_speed_index(req_speed_index),
      .req_load_value(req_load_value), .req_query_altitude(req_query_altitude),
      .req_query_speed(req_query_speed),
      .rsp_valid(rsp_valid), .rsp_rate_out(rsp_rate_out), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // One expected result beat.
   typedef struct {
      logic [19:0] rate;
      logic        status;
   } rate_beat_type;

   // One row of the directed table; a typed expectation is used when has_answer is set.
   typedef struct {
      op_type      op;
      logic [3:0]  alt_idx;
      logic [3:0]  spd_idx;
      logic [15:0] value;
      logic [15:0] alt_q;
      logic [15:0] spd_q;
      bit          has_answer;
      logic [19:0] answer_rate;
      logic        answer_status;
   } directed_row_type;

   // Shadow copy of the table and the used-level counts.
   logic [15:0] alt_levels [NUM_ALT];
   logic [15:0] spd_levels [NUM_SPD];
   logic [15:0] rate_grid [NUM_ALT*NUM_SPD];
   logic [4:0]  alt_used;
   logic [4:0]  spd_used;

   rate_beat_type pending_rates [$];
   int  mismatches;
   int  quiet_cycles;
   bit  quiet_run;

   // The clock runs with a period of 10 time units.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Brackets x on one axis; returns the two level indices and the Q16 weight of the upper one.
   function automatic void bracket_axis(input bit on_speed, input int unsigned x,
                                        output int lo, output int hi,
                                        output longint unsigned wt);
      int n;
      int last;
      int unsigned a;
      int unsigned b;
      n  = on_speed ? ((spd_used > NUM_SPD) ? NUM_SPD : spd_used)
                    : ((alt_used > NUM_ALT) ? NUM_ALT : alt_used);
      last = n - 1;
      wt = 0;
      if (x <= (on_speed ? spd_levels[0] : alt_levels[0])) begin
         lo = 0; hi = 0;
         return;
      end
      if (x >= (on_speed ? spd_levels[last] : alt_levels[last])) begin
         lo = last; hi = last;
         return;
      end
      for (int i = 0; i + 1 < n; i++) begin
         a = on_speed ? spd_levels[i] : alt_levels[i];
         b = on_speed ? spd_levels[i+1] : alt_levels[i+1];
         if (x >= a && x <= b) begin
            lo = i; hi = i + 1;
            if (b != a) wt = ((longint'(x - a)) << 16) / (b - a);
            return;
         end
      end
      // Levels out of order: nothing brackets the value, so the last level stands alone.
      lo = last; hi = last;
   endfunction

   // Works out the rate a query should give from the shadow table.
   function automatic rate_beat_type interpolate_rate(input logic [15:0] qa,
                                                      input logic [15:0] qs);
      rate_beat_type r;
      int a0, a1, s0, s1;
      longint unsigned ty, tx, row_lo, row_hi, acc;
      if (alt_used == 0 || spd_used == 0) begin
         r.rate = '0;
         r.status = STATUS_EMPTY;
         return r;
      end
      bracket_axis(1'b0, qa, a0, a1, ty);
      bracket_axis(1'b1, qs, s0, s1, tx);
      row_lo = rate_grid[a0*NUM_SPD+s0] * (ONE_Q16 - tx) + rate_grid[a0*NUM_SPD+s1] * tx;
      row_hi = rate_grid[a1*NUM_SPD+s0] * (ONE_Q16 - tx) + rate_grid[a1*NUM_SPD+s1] * tx;
      acc = row_lo * (ONE_Q16 - ty) + row_hi * ty;
      r.rate = acc[47:28];
      r.status = STATUS_OK;
      return r;
   endfunction

   // Applies a load to the shadow table.
   function automatic void apply_load(input op_type op, input logic [3:0] ai,
                                      input logic [3:0] si, input logic [15:0] v);
      case (op)
         OP_LOAD_ALT:  alt_levels[ai] = v;
         OP_LOAD_SPD:  spd_levels[si] = v;
         OP_LOAD_GRID: rate_grid[ai*NUM_SPD+si] = v;
         default: ;
      endcase
   endfunction

   // Sends one request beat, with a random idle burst first unless the run is in its quiet tail.
   // When has_answer is set the typed answer is queued instead of the predicted one.
   task automatic send_request(input op_type op, input logic [3:0] ai, input logic [3:0] si,
                               input logic [15:0] v, input logic [15:0] qa,
                               input logic [15:0] qs, input bit has_answer = 0,
                               input rate_beat_type answer = '{default: '0});
      if (!quiet_run && $urandom_range(0, 3) == 0) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_start          <= 1'b1;
      req_op             <= op;
      req_altitude_index <= ai;
      req_speed_index    <= si;
      req_load_value     <= v;
      req_query_altitude <= qa;
      req_query_speed    <= qs;
      @(posedge clock);
      while (req_busy) @(posedge clock);
      if (op == OP_QUERY)
         pending_rates.insert(pending_rates.size(),
                              has_answer ? answer : interpolate_rate(qa, qs));
      else apply_load(op, ai, si, v);
   endtask

   // Stops requests and waits until every result has come back and the sequencer is quiet.
   task automatic drain;
      req_start <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one used-level count through the register channel.
   task automatic write_count(input csr_idx_type idx, input logic [4:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ALT_USED) alt_used = data;
      else spd_used = data;
   endtask

   // Rewrites one axis with ascending levels; a zero step now and then repeats a level.
   task automatic load_ascending_levels(input op_type op);
      int unsigned lv;
      int unsigned step_max;
      lv = $urandom_range(0, 2000);
      step_max = $urandom_range(0, 1) ? 4000 : 300;
      for (int i = 0; i < 16; i++) begin
         send_request(op, 4'(i), 4'(i), 16'(lv), 16'($urandom), 16'($urandom));
         lv = lv + (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, step_max));
         if (lv > 65535) lv = 65535;
      end
   endtask

   // Picks a query coordinate: the extremes, an exact level, any value, or somewhere inside the levels.
   function automatic logic [15:0] pick_coordinate(input bit on_speed);
      int n;
      int unsigned lo_v, hi_v, v;
      n = on_speed ? ((spd_used > NUM_SPD || spd_used == 0) ? NUM_SPD : spd_used)
                   : ((alt_used > NUM_ALT || alt_used == 0) ? NUM_ALT : alt_used);
      lo_v = on_speed ? spd_levels[0] : alt_levels[0];
      hi_v = on_speed ? spd_levels[n-1] : alt_levels[n-1];
      if (lo_v > hi_v) begin
         v = lo_v; lo_v = hi_v; hi_v = v;
      end
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return on_speed ? spd_levels[$urandom_range(0, n-1)]
                               : alt_levels[$urandom_range(0, n-1)];
         4: return 16'($urandom);
         default: return 16'($urandom_range(lo_v, hi_v));
      endcase
   endfunction

   // Random mix: mostly queries, grid reloads, and a few stray level writes that may break
   // the ordering of the levels.
   task automatic random_traffic(input int count);
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 62)
            send_request(OP_QUERY, 4'($urandom), 4'($urandom), 16'($urandom),
                         pick_coordinate(1'b0), pick_coordinate(1'b1));
         else if (pick < 92)
            send_request(OP_LOAD_GRID, 4'($urandom), 4'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
         else
            send_request((pick < 96) ? OP_LOAD_ALT : OP_LOAD_SPD, 4'($urandom), 4'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   // Result checker: every beat with rsp_valid is compared with the oldest expectation.
   always @(posedge clock) begin
      rate_beat_type want;
      if (!reset && rsp_valid) begin
         if (pending_rates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result beat: rate %0h status %0b", rsp_rate_out, rsp_status);
         end else begin
            want = pending_rates.pop_front();
            if (rsp_rate_out !== want.rate || rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Result mismatch: expected rate %0h status %0b, got rate %0h status %0b",
                           want.rate, want.status, rsp_rate_out, rsp_status);
            end
         end
      end
   end

   // Watchdog: any accepted beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_start && !req_busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      directed_row_type plan [$];
      // Counts sit at zero after reset, so every query here must report an empty table.
      plan = '{
         '{OP_QUERY,     4'h0, 4'h0, 16'h0000, 16'h0000, 16'h0000, 1, 20'h0, STATUS_EMPTY},
         '{OP_QUERY,     4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 20'h0, STATUS_EMPTY},
         '{OP_LOAD_ALT,  4'hF, 4'h0, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 20'h0, STATUS_OK},
         '{OP_LOAD_ALT,  4'h0, 4'hF, 16'h0000, 16'hFFFF, 16'h0000, 0, 20'h0, STATUS_OK},
         '{OP_LOAD_SPD,  4'h0, 4'hF, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 20'h0, STATUS_OK},
         '{OP_LOAD_SPD,  4'hF, 4'h0, 16'h0000, 16'hFFFF, 16'h0000, 0, 20'h0, STATUS_OK},
         '{OP_LOAD_GRID, 4'hF, 4'hF, 16'hFFFF, 16'h5555, 16'hAAAA, 0, 20'h0, STATUS_OK},
         '{OP_LOAD_GRID, 4'h0, 4'h0, 16'h0000, 16'hAAAA, 16'h5555, 0, 20'h0, STATUS_OK},
         '{OP_QUERY,     4'h5, 4'hA, 16'h1234, 16'h8000, 16'h0001, 1, 20'h0, STATUS_EMPTY}
      };
      mismatches = 0;
      quiet_run  = 0;
      alt_used   = '0;
      spd_used   = '0;
      reset = 1'b1;
      req_start = 1'b0; req_op = '0; req_altitude_index = '0; req_speed_index = '0;
      req_load_value = '0; req_query_altitude = '0; req_query_speed = '0;
      csr_valid = 1'b0; csr_index = 1'b0; csr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i])
         send_request(plan[i].op, plan[i].alt_idx, plan[i].spd_idx, plan[i].value,
                      plan[i].alt_q, plan[i].spd_q, plan[i].has_answer,
                      '{rate: plan[i].answer_rate, status: plan[i].answer_status});

      // Fill the whole grid and both level lists, so no later query touches an unwritten entry.
      for (int r = 0; r < NUM_ALT; r++)
         for (int c = 0; c < NUM_SPD; c++)
            send_request(OP_LOAD_GRID, 4'(r), 4'(c), 16'($urandom), 16'($urandom),
                         16'($urandom));
      load_ascending_levels(OP_LOAD_ALT);
      load_ascending_levels(OP_LOAD_SPD);
      drain();

      // Phases cover full tables, single levels, counts above capacity, and one empty axis.
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin write_count(CSR_ALT_USED, 5'd16); write_count(CSR_SPD_USED, 5'd16); end
            1: begin write_count(CSR_ALT_USED, 5'd1);  write_count(CSR_SPD_USED, 5'd16); end
            2: begin write_count(CSR_ALT_USED, 5'd16); write_count(CSR_SPD_USED, 5'd1);  end
            3: begin write_count(CSR_ALT_USED, 5'd31); write_count(CSR_SPD_USED, 5'd17); end
            4: begin write_count(CSR_ALT_USED, 5'd0);  write_count(CSR_SPD_USED, 5'd9);  end
            5: begin write_count(CSR_ALT_USED, 5'd7);  write_count(CSR_SPD_USED, 5'd0);  end
            6: begin write_count(CSR_ALT_USED, 5'd2);  write_count(CSR_SPD_USED, 5'd2);  end
            default: begin
               write_count(CSR_ALT_USED, 5'($urandom_range(1, 31)));
               write_count(CSR_SPD_USED, 5'($urandom_range(1, 31)));
            end
         endcase
         // The last phase runs back to back with no idle gaps.
         if (phase == 9) quiet_run = 1;
         load_ascending_levels(OP_LOAD_ALT);
         load_ascending_levels(OP_LOAD_SPD);
         random_traffic((phase == 4 || phase == 5) ? 40 : RANDOM_PER_PHASE);
         drain();
      end

      if (mismatches == 0 && pending_rates.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
